// File: src/scha_pkg.sv
`timescale 1ns / 1ps
package scha_pkg;

    localparam int NUM_CLASSES = 16;
    localparam logic [4:0] NO_CLASS = 5'd16;
    // page size, a power of two so page index and offset are bit fields
    localparam int PAGE_BYTES = 4096;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_BIG  = 3'd1,
        ST_NO_PAGES = 3'd2,
        ST_LEAKED   = 3'd3,
        ST_NULL     = 3'd4
    } t_status;

    localparam int CFG_HEAP_BASE = 0;
    localparam int CFG_MAX_PAGES = 1;

    // classified command passed from front to back
    typedef struct packed {
        t_cmd        cmd;
        logic [16:0] aligned;
        logic [4:0]  cls;
        logic [31:0] addr;
    } t_item;

    function automatic logic [9:0] class_bytes(input logic [3:0] c);
        logic [9:0] b;
        begin
            unique case (c)
                4'd0:  b = 10'd16;
                4'd1:  b = 10'd24;
                4'd2:  b = 10'd32;
                4'd3:  b = 10'd40;
                4'd4:  b = 10'd48;
                4'd5:  b = 10'd64;
                4'd6:  b = 10'd80;
                4'd7:  b = 10'd96;
                4'd8:  b = 10'd112;
                4'd9:  b = 10'd128;
                4'd10: b = 10'd160;
                4'd11: b = 10'd192;
                4'd12: b = 10'd224;
                4'd13: b = 10'd256;
                4'd14: b = 10'd320;
                default: b = 10'd512;
            endcase
            return b;
        end
    endfunction

    // first class that holds the size, NO_CLASS if none
    function automatic logic [4:0] find_class(input logic [16:0] sz);
        logic [4:0] r;
        begin
            r = NO_CLASS;
            for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
                if (sz <= {7'd0, class_bytes(4'(i))}) r = 5'(i);
            end
            return r;
        end
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        end
    endfunction

endpackage

// File: src/scha_front.sv
`timescale 1ns / 1ps
// accepts commands, aligns sizes, picks the class, queues for the back end
module scha_front
    import scha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_req_size,
    input  logic [31:0] i_addr,
    input  logic [15:0] i_obj_size,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_pop
);
    // two-entry queue
    t_item      r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    logic       push;
    t_item      item;
    logic [16:0] al;

    assign o_busy  = (r_cnt == 2'd2);
    assign push    = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];

    always_comb begin
        al = ({1'b0, i_req_size} + 17'd7) & ~17'd7;
        item.cmd     = t_cmd'(i_cmd);
        item.addr    = i_addr;
        item.aligned = al;
        if (t_cmd'(i_cmd) == CMD_FREE) item.cls = find_class({1'b0, i_obj_size});
        else item.cls = find_class(al);
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
        end
        if (push) r_q[r_wp] <= item;
    end
endmodule

// File: src/scha_back.sv
`timescale 1ns / 1ps
// executes commands: stack memory read in S_READ, update in S_EXEC
module scha_back
    import scha_pkg::*;
#(
    parameter int PAGE_HEADER_BYTES = 32,
    parameter int STACK_DEPTH       = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [31:0] i_heap_base,
    input  logic [15:0] i_max_pages,
    output logic        o_strobe,
    output logic [31:0] o_result_addr,
    output logic [4:0]  o_size_class,
    output logic        o_reused,
    output logic        o_new_page,
    output logic [2:0]  o_status,
    output logic        o_in_heap,
    output logic [31:0] o_alloc_bytes,
    output logic [31:0] o_peak_bytes,
    output logic [31:0] o_object_count,
    output logic [31:0] o_reuse_bytes,
    output logic [15:0] o_pages_used
);
    localparam int SD_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FL_W  = $clog2(STACK_DEPTH + 1);
    localparam int PG_SH = $clog2(PAGE_BYTES);
    localparam int UB_W  = PG_SH + 1;
    localparam logic [16:0] CAP = 17'(PAGE_BYTES - PAGE_HEADER_BYTES);
    localparam logic [31:0] HDR = 32'(PAGE_HEADER_BYTES);

    typedef enum logic [1:0] {
        S_READ = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    logic [31:0] r_mem [NUM_CLASSES * (1 << SD_W)];
    logic [31:0] r_rd;
    logic [FL_W-1:0] r_fill [NUM_CLASSES];
    logic [15:0] r_pages;
    logic [UB_W-1:0] r_used;
    logic [31:0] r_tot, r_peak, r_obj, r_reu;
    t_item r_it;

    logic [3:0]      cidx;
    logic [FL_W-1:0] fill;
    logic            cls_ok;
    logic [SD_W-1:0] push_slot;

    assign cidx     = r_it.cls[3:0];
    assign cls_ok   = !r_it.cls[4];
    assign fill     = r_fill[cidx];
    assign push_slot = SD_W'(fill);
    assign o_pop    = (r_state == S_READ) && i_valid;

    // outputs of exec
    logic [31:0] res_addr;
    logic        res_reused, res_new, res_in, do_pop, do_push, do_bump, do_open;
    t_status     res_st;
    logic [31:0] n_tot, n_peak, n_obj, n_reu, new_page_addr, cur_page_addr, off;
    logic [32:0] end_addr;

    always_comb begin
        res_addr = '0; res_reused = 1'b0; res_new = 1'b0; res_in = 1'b0;
        res_st = ST_OK; do_pop = 1'b0; do_push = 1'b0; do_bump = 1'b0; do_open = 1'b0;
        n_tot = r_tot; n_peak = r_peak; n_obj = r_obj; n_reu = r_reu;
        // page addresses follow the current heap base
        new_page_addr = i_heap_base + (32'(r_pages) << PG_SH);
        cur_page_addr = i_heap_base + (32'(r_pages - 16'd1) << PG_SH);
        end_addr = {1'b0, i_heap_base} + (33'({1'b0, r_pages} + 17'd1) << PG_SH);
        off = r_it.addr - i_heap_base;
        unique case (r_it.cmd)
            CMD_ALLOC: begin
                if (cls_ok && fill != '0) begin
                    do_pop = 1'b1;
                    res_addr = r_rd;
                    res_reused = 1'b1;
                    n_reu = sat_add(r_reu, {22'd0, class_bytes(cidx)});
                end else if (r_it.aligned > CAP) begin
                    res_st = ST_TOO_BIG;
                end else if (r_pages == 16'd0 ||
                             ({{(17-UB_W){1'b0}}, r_used} + r_it.aligned) > CAP) begin
                    // a new page may end exactly at the top of the address space
                    if (r_pages >= i_max_pages || end_addr > 33'h1_0000_0000) begin
                        res_st = ST_NO_PAGES;
                    end else begin
                        do_open = 1'b1;
                        res_new = 1'b1;
                        res_addr = new_page_addr + HDR;
                    end
                end else begin
                    do_bump = 1'b1;
                    res_addr = cur_page_addr + HDR + 32'(r_used);
                end
                if (res_st == ST_OK) begin
                    n_tot = sat_add(r_tot, {15'd0, r_it.aligned});
                    if (n_tot > r_peak) n_peak = n_tot;
                    n_obj = sat_add(r_obj, 32'd1);
                end
            end
            CMD_FREE: begin
                if (r_it.addr == '0) res_st = ST_NULL;
                else if (!cls_ok || fill >= FL_W'(STACK_DEPTH)) res_st = ST_LEAKED;
                else do_push = 1'b1;
            end
            CMD_QUERY: begin
                if (r_it.addr != '0 && r_it.addr >= i_heap_base
                    && {16'd0, r_pages} > (off >> PG_SH)
                    && 32'(off[PG_SH-1:0]) >= HDR)
                    res_in = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_READ;
            o_strobe <= 1'b0;
            r_pages  <= '0;
            r_used   <= '0;
            r_tot <= '0; r_peak <= '0; r_obj <= '0; r_reu <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) r_fill[i] <= '0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_READ: if (i_valid) r_state <= S_EXEC;
                S_EXEC: begin
                    r_state  <= S_READ;
                    o_strobe <= 1'b1;
                    if (r_it.cmd == CMD_CLEAR) begin
                        r_pages <= '0; r_used <= '0;
                        r_tot <= '0; r_peak <= '0; r_obj <= '0; r_reu <= '0;
                        for (int i = 0; i < NUM_CLASSES; i++) r_fill[i] <= '0;
                    end else begin
                        r_tot <= n_tot; r_peak <= n_peak; r_obj <= n_obj; r_reu <= n_reu;
                        if (do_pop)  r_fill[cidx] <= fill - FL_W'(1);
                        if (do_push) r_fill[cidx] <= fill + FL_W'(1);
                        if (do_open) begin
                            r_pages <= r_pages + 16'd1;
                            r_used  <= UB_W'(r_it.aligned);
                        end
                        if (do_bump) r_used <= r_used + UB_W'(r_it.aligned);
                    end
                end
                default: r_state <= S_READ;
            endcase
        end
        if (o_pop) r_it <= i_item;
        // stack memory: read top entry at fetch, write pushes at exec
        if (o_pop)
            r_rd <= r_mem[{i_item.cls[3:0],
                           SD_W'(r_fill[i_item.cls[3:0]] - FL_W'(1))}];
        if (r_state == S_EXEC && do_push && r_it.cmd == CMD_FREE)
            r_mem[{cidx, push_slot}] <= r_it.addr;
        if (r_state == S_EXEC) begin
            o_result_addr <= res_addr;
            o_size_class  <= (r_it.cmd == CMD_ALLOC || (r_it.cmd == CMD_FREE
                              && r_it.addr != '0)) ? r_it.cls : NO_CLASS;
            o_reused      <= res_reused;
            o_new_page    <= res_new;
            o_status      <= res_st;
            o_in_heap     <= res_in;
            o_alloc_bytes     <= (r_it.cmd == CMD_CLEAR) ? '0 : n_tot;
            o_peak_bytes      <= (r_it.cmd == CMD_CLEAR) ? '0 : n_peak;
            o_object_count    <= (r_it.cmd == CMD_CLEAR) ? '0 : n_obj;
            o_reuse_bytes     <= (r_it.cmd == CMD_CLEAR) ? '0 : n_reu;
            o_pages_used      <= (r_it.cmd == CMD_CLEAR) ? '0
                                 : (do_open ? r_pages + 16'd1 : r_pages);
        end
    end
endmodule

// File: src/size_class_heap_allocator.sv
`timescale 1ns / 1ps
// channel   | direction | handshake                   | payload
// command   | in        | start & !busy               | i_cmd i_req_size i_addr i_obj_size
// config    | in        | i_cfg_valid & o_cfg_ready   | i_cfg_index i_cfg_data
// result    | out       | o_done strobe, one cycle    | o_result_addr .. o_pages_used
//
// in the back end each command first reads the top of its class stack from the
// stack memory, then updates state and registers the result. the result and its
// o_done strobe are registered by that update. with the back end idle a command
// goes straight from the queue to the read; else it waits for the command in
// progress and each one queued ahead: no command is read before the last is updated.
// a two-entry queue sits in front; busy rises only when it is full.
// the receiver cannot stall: each result beat is taken in its strobe cycle.
// reset is synchronous, active low; stack contents are not cleared, fill counts are.
module size_class_heap_allocator
    import scha_pkg::*;
#(
    parameter int PAGE_HEADER_BYTES = 32,
    parameter int STACK_DEPTH       = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_req_size,
    input  logic [31:0] i_addr,
    input  logic [15:0] i_obj_size,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_done,
    output logic [31:0] o_result_addr,
    output logic [4:0]  o_size_class,
    output logic        o_reused,
    output logic        o_new_page,
    output logic [2:0]  o_status,
    output logic        o_in_heap,
    output logic [31:0] o_alloc_bytes,
    output logic [31:0] o_peak_bytes,
    output logic [31:0] o_object_count,
    output logic [31:0] o_reuse_bytes,
    output logic [15:0] o_pages_used
);
    // configuration registers, written any time (only while idle by contract)
    logic [31:0] r_heap_base;
    logic [15:0] r_max_pages;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_max_pages <= 16'd256;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 1'(CFG_HEAP_BASE)) r_heap_base <= i_cfg_data;
            if (i_cfg_index == 1'(CFG_MAX_PAGES)) r_max_pages <= i_cfg_data[15:0];
        end
    end

    logic  q_valid, q_pop;
    t_item q_item;

    scha_front u_front (
        .i_clk, .i_rst_n,
        .i_start(start), .o_busy(busy),
        .i_cmd, .i_req_size, .i_addr, .i_obj_size,
        .o_valid(q_valid), .o_item(q_item), .i_pop(q_pop)
    );

    scha_back #(
        .PAGE_HEADER_BYTES(PAGE_HEADER_BYTES),
        .STACK_DEPTH(STACK_DEPTH)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_item(q_item), .o_pop(q_pop),
        .i_heap_base(r_heap_base), .i_max_pages(r_max_pages),
        .o_strobe(o_done),
        .o_result_addr, .o_size_class, .o_reused, .o_new_page, .o_status,
        .o_in_heap, .o_alloc_bytes, .o_peak_bytes, .o_object_count,
        .o_reuse_bytes, .o_pages_used
    );

    // a pop never leaves the queue empty-handed
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    // peak never below running total
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_peak_bytes >= o_alloc_bytes) else $error("peak below total");
    // results never come on back-to-back cycles
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back-to-back results");
endmodule
